// ===== rtl/core/pfc_pkg.sv =====
// shared types and constants for the print format checker
`default_nettype none

package pfc_pkg;

  localparam int unsigned FORMAT_ROOM = 64;
  localparam int unsigned CNT_W       = 10;
  localparam int unsigned MAX_BYTES   = 4;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ELL     = 8'h6c;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam logic [1:0] PH_LITERAL = 2'd0;
  localparam logic [1:0] PH_PERCENT = 2'd1;
  localparam logic [1:0] PH_CONV    = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_INT  = 2'd1;
  localparam logic [1:0] KIND_REAL = 2'd2;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                nb;
    logic                      verdict;
    logic [1:0]                kind;
  } run_t;

endpackage

`default_nettype wire

// ===== rtl/core/pfc_scan.sv =====
// scan state and per-byte decode into a run of results
`default_nettype none

module pfc_scan (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    format_char,
  input  wire logic          last_of_format,
  output pfc_pkg::run_t      run
);
  import pfc_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic       refused_r, refused_nxt;
  logic [7:0] written_r, written_nxt;

  logic [CNT_W-1:0] wcnt;
  logic             conv_en;
  logic             room1, room2;
  run_t             run_c;

  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    refused_nxt = refused_r;
    run_c       = '0;
    wcnt        = CNT_W'(written_r);
    conv_en     = 1'b0;

    room1 = (wcnt + CNT_W'(1)) < CNT_W'(FORMAT_ROOM);
    room2 = (wcnt + CNT_W'(2)) < CNT_W'(FORMAT_ROOM);

    if (!refused_r) begin
      case (phase_r)
        PH_LITERAL: begin
          if (format_char == CH_NUL) begin
            refused_nxt = 1'b1;
          end else if (format_char == CH_PERCENT) begin
            phase_nxt = PH_PERCENT;
          end else if (!room1) begin
            refused_nxt = 1'b1;
          end else begin
            run_c.bytes[0] = format_char;
            run_c.nb       = 3'd1;
          end
        end
        PH_PERCENT: begin
          if (format_char == CH_PERCENT) begin
            if (!room2) begin
              refused_nxt = 1'b1;
            end else begin
              run_c.bytes[0] = CH_PERCENT;
              run_c.bytes[1] = CH_PERCENT;
              run_c.nb       = 3'd2;
              phase_nxt      = PH_LITERAL;
            end
          end else if (kind_r != KIND_NONE || !room1) begin
            refused_nxt = 1'b1;
          end else begin
            run_c.bytes[0] = CH_PERCENT;
            run_c.nb       = 3'd1;
            phase_nxt      = PH_CONV;
            conv_en        = 1'b1;
          end
        end
        default: begin
          conv_en = 1'b1;
        end
      endcase
    end

    wcnt  = CNT_W'(written_r) + CNT_W'(run_c.nb);
    room1 = (wcnt + CNT_W'(1)) < CNT_W'(FORMAT_ROOM);
    room2 = (wcnt + CNT_W'(2)) < CNT_W'(FORMAT_ROOM);

    if (conv_en) begin
      if (format_char inside {[CH_ZERO:CH_NINE], CH_MINUS, CH_PLUS, CH_SPACE,
                              CH_HASH, CH_DOT}) begin
        if (room1) begin
          run_c.bytes[run_c.nb[1:0]] = format_char;
          run_c.nb = run_c.nb + 3'd1;
        end else begin
          refused_nxt = 1'b1;
        end
      end else if (format_char inside {"d", "i", "o", "u", "x", "X"}) begin
        kind_nxt = KIND_INT;
        if (!room2) begin
          refused_nxt = 1'b1;
        end else begin
          run_c.bytes[run_c.nb[1:0]]          = CH_ELL;
          run_c.bytes[run_c.nb[1:0] + 2'd1]   = CH_ELL;
          if ((wcnt + CNT_W'(3)) < CNT_W'(FORMAT_ROOM)) begin
            run_c.bytes[run_c.nb[1:0] + 2'd2] = format_char;
            run_c.nb  = run_c.nb + 3'd3;
            phase_nxt = PH_LITERAL;
          end else begin
            run_c.nb    = run_c.nb + 3'd2;
            refused_nxt = 1'b1;
          end
        end
      end else if (format_char inside {"f", "F", "e", "E", "g", "G", "a", "A"}) begin
        kind_nxt = KIND_REAL;
        if (room1) begin
          run_c.bytes[run_c.nb[1:0]] = format_char;
          run_c.nb  = run_c.nb + 3'd1;
          phase_nxt = PH_LITERAL;
        end else begin
          refused_nxt = 1'b1;
        end
      end else begin
        refused_nxt = 1'b1;
      end
    end

    written_nxt = written_r + 8'(run_c.nb);

    if (last_of_format) begin
      run_c.verdict = 1'b1;
      run_c.kind    = (refused_nxt || phase_nxt != PH_LITERAL) ? KIND_NONE : kind_nxt;
      phase_nxt     = PH_LITERAL;
      kind_nxt      = KIND_NONE;
      refused_nxt   = 1'b0;
      written_nxt   = 8'd0;
    end
  end

  assign run = run_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LITERAL;
      kind_r    <= KIND_NONE;
      refused_r <= 1'b0;
      written_r <= 8'd0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      refused_r <= refused_nxt;
      written_r <= written_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pfc_emit.sv =====
// result register that plays out one run, one transaction per cycle while out_stall is low
`default_nettype none

module pfc_emit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire pfc_pkg::run_t run,
  output logic               load_ok,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_rebuilt_char,
  output logic               out_is_verdict,
  output logic [1:0]         out_format_kind,
  output logic               out_last_of_run
);
  import pfc_pkg::*;

  run_t       run_r;
  logic       full_r, full_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic [2:0] total_in;
  logic       on_byte;
  logic       take;

  assign total    = run_r.nb + 3'(run_r.verdict);
  assign total_in = run.nb + 3'(run.verdict);
  assign on_byte  = idx_r < run_r.nb;

  assign out_valid        = full_r;
  assign out_rebuilt_char = on_byte ? run_r.bytes[idx_r[1:0]] : 8'd0;
  assign out_is_verdict   = !on_byte;
  assign out_format_kind  = on_byte ? KIND_NONE : run_r.kind;
  assign out_last_of_run  = idx_r == (total - 3'd1);

  assign take    = full_r && !out_stall;
  assign load_ok = !full_r || (take && out_last_of_run);

  always_comb begin
    full_nxt = full_r;
    idx_nxt  = idx_r;
    if (load && load_ok) begin
      full_nxt = total_in != 3'd0;
      idx_nxt  = 3'd0;
    end else if (take) begin
      if (out_last_of_run) begin
        full_nxt = 1'b0;
        idx_nxt  = 3'd0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      idx_r  <= 3'd0;
    end else begin
      full_r <= full_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ok) begin
      run_r <= run;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/print_format_checker.sv =====
// top level of the print format checker
//
// takes a printf-style format one byte per input transaction, with
// in_last_of_format on the final byte, and gives the rebuilt format one
// byte per output transaction: literal bytes and doubled percent signs
// are copied, an integer conversion gets "ll" put before its spec and a
// real conversion passes unchanged. the final byte is followed by a
// verdict transaction (out_is_verdict high, out_format_kind 0 bad,
// 1 integer, 2 real), after which the block is ready for a new format.
// each input byte yields a run of zero to five output transactions,
// the last one flagged by out_last_of_run.
// the run of an accepted byte is loaded into the output register and shows
// in the next cycle. one byte per cycle is taken while each byte gives at
// most one result and out_stall is low; a byte that gives more results
// holds the input until the single output register has played out its run.
// out_stall holds the current result, and the input is stalled until
// the last result of the run in the output register is taken. reset
// clears the scan state and empties the output register.
`default_nettype none

module print_format_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_format_char,
  input  wire logic       in_last_of_format,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_rebuilt_char,
  output logic            out_is_verdict,
  output logic [1:0]      out_format_kind,
  output logic            out_last_of_run
);
  import pfc_pkg::*;

  run_t run;
  logic load_ok;
  logic accept;

  assign in_stall = !load_ok;
  assign accept   = in_valid && load_ok;

  pfc_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .format_char    (in_format_char),
    .last_of_format (in_last_of_format),
    .run            (run)
  );

  pfc_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (in_valid),
    .run              (run),
    .load_ok          (load_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rebuilt_char (out_rebuilt_char),
    .out_is_verdict   (out_is_verdict),
    .out_format_kind  (out_format_kind),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

`default_nettype wire

// ===== test/tb_print_format_checker.sv =====
// testbench for the print format checker: random and directed formats checked against a predictor
`timescale 1ns / 1ps

module tb_print_format_checker;
  import pfc_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } fmt_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       verdict;
    logic [1:0] kind;
    logic       last;
  } rebuilt_t;

  localparam logic [7:0] INT_SPECS [6]  = '{"d", "i", "o", "u", "x", "X"};
  localparam logic [7:0] REAL_SPECS [8] = '{"f", "F", "e", "E", "g", "G", "a", "A"};
  localparam logic [7:0] LEN_MODS [4]   = '{CH_ELL, "h", "z", "j"};
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES  = 20;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_format_char = '0;
  logic       in_last_of_format = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_rebuilt_char;
  logic       out_is_verdict;
  logic [1:0] out_format_kind;
  logic       out_last_of_run;

  fmt_byte_t   format_bytes[$];
  rebuilt_t    expected_rebuilt[$];
  rebuilt_t    run_buf[$];
  int unsigned total_items = 0;
  int unsigned items_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  logic [1:0]  scan_ph;
  logic [1:0]  conv_kind;
  logic        refused_fmt;
  int unsigned written;

  print_format_checker i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_format_char    (in_format_char),
    .in_last_of_format (in_last_of_format),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rebuilt_char  (out_rebuilt_char),
    .out_is_verdict    (out_is_verdict),
    .out_format_kind   (out_format_kind),
    .out_last_of_run   (out_last_of_run)
  );

  always #5 clk = ~clk;

  assign in_idle_pct  = (items_accepted < total_items / 3) ? 22 :
                        (items_accepted < 2 * total_items / 3) ? 52 : 0;
  assign out_idle_pct = (items_accepted < total_items / 3) ? 52 :
                        (items_accepted < 2 * total_items / 3) ? 22 : 0;

  function automatic bit is_flag(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS || c == CH_PLUS ||
           c == CH_SPACE || c == CH_HASH || c == CH_DOT;
  endfunction

  function automatic bit is_int_spec(input logic [7:0] c);
    bit hit;
    hit = 1'b0;
    foreach (INT_SPECS[k]) if (INT_SPECS[k] == c) hit = 1'b1;
    return hit;
  endfunction

  function automatic bit is_real_spec(input logic [7:0] c);
    bit hit;
    hit = 1'b0;
    foreach (REAL_SPECS[k]) if (REAL_SPECS[k] == c) hit = 1'b1;
    return hit;
  endfunction

  function automatic bit fits(input int unsigned count);
    return written + count < FORMAT_ROOM;
  endfunction

  task automatic emit_char(input logic [7:0] c);
    run_buf.push_back('{ch: c, verdict: 1'b0, kind: KIND_NONE, last: 1'b0});
    written++;
  endtask

  task automatic conv_char(input logic [7:0] c);
    if (is_flag(c)) begin
      if (!fits(1)) refused_fmt = 1'b1;
      else emit_char(c);
    end else if (is_int_spec(c)) begin
      conv_kind = KIND_INT;
      if (!fits(2)) begin
        refused_fmt = 1'b1;
      end else begin
        emit_char(CH_ELL);
        emit_char(CH_ELL);
        if (!fits(1)) begin
          refused_fmt = 1'b1;
        end else begin
          emit_char(c);
          scan_ph = PH_LITERAL;
        end
      end
    end else if (is_real_spec(c)) begin
      conv_kind = KIND_REAL;
      if (!fits(1)) begin
        refused_fmt = 1'b1;
      end else begin
        emit_char(c);
        scan_ph = PH_LITERAL;
      end
    end else begin
      refused_fmt = 1'b1;
    end
  endtask

  task automatic clear_scan();
    scan_ph     = PH_LITERAL;
    conv_kind   = KIND_NONE;
    refused_fmt = 1'b0;
    written     = 0;
  endtask

  task automatic predict_rebuilt(input logic [7:0] c, input logic fin);
    rebuilt_t r;
    run_buf.delete();
    if (!refused_fmt) begin
      case (scan_ph)
        PH_LITERAL: begin
          if (c == CH_NUL) refused_fmt = 1'b1;
          else if (c == CH_PERCENT) scan_ph = PH_PERCENT;
          else if (!fits(1)) refused_fmt = 1'b1;
          else emit_char(c);
        end
        PH_PERCENT: begin
          if (c == CH_PERCENT) begin
            if (!fits(2)) begin
              refused_fmt = 1'b1;
            end else begin
              emit_char(CH_PERCENT);
              emit_char(CH_PERCENT);
              scan_ph = PH_LITERAL;
            end
          end else if (conv_kind != KIND_NONE || !fits(1)) begin
            refused_fmt = 1'b1;
          end else begin
            emit_char(CH_PERCENT);
            scan_ph = PH_CONV;
            conv_char(c);
          end
        end
        default: conv_char(c);
      endcase
    end
    if (fin) begin
      r = '{ch: 8'h00, verdict: 1'b1, kind: conv_kind, last: 1'b0};
      if (refused_fmt || scan_ph != PH_LITERAL) r.kind = KIND_NONE;
      run_buf.push_back(r);
      clear_scan();
    end
    if (run_buf.size() != 0) begin
      r = run_buf.pop_back();
      r.last = 1'b1;
      run_buf.push_back(r);
    end
    foreach (run_buf[k]) expected_rebuilt.push_back(run_buf[k]);
  endtask

  function automatic logic [7:0] rand_literal();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_PERCENT);
    return c;
  endfunction

  function automatic logic [7:0] rand_flag();
    int unsigned r;
    r = $urandom_range(0, 14);
    case (r)
      10: return CH_MINUS;
      11: return CH_PLUS;
      12: return CH_SPACE;
      13: return CH_HASH;
      14: return CH_DOT;
      default: return CH_ZERO + 8'(r);
    endcase
  endfunction

  function automatic logic [7:0] rand_spec();
    if ($urandom_range(0, 1) == 0) return INT_SPECS[$urandom_range(0, 5)];
    return REAL_SPECS[$urandom_range(0, 7)];
  endfunction

  task automatic add_text(input string s, input bit fin);
    for (int k = 0; k < s.len(); k++)
      format_bytes.push_back('{ch: s[k], fin: fin && (k == s.len() - 1)});
  endtask

  task automatic add_random_format();
    logic [7:0]  fmt[$];
    int unsigned pick;
    int unsigned brk;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 8))
        fmt.push_back(($urandom_range(0, 3) == 0) ? CH_PERCENT : 8'($urandom_range(0, 255)));
    end else begin
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(56, 64) : $urandom_range(0, 5))
        fmt.push_back(rand_literal());
      if ($urandom_range(0, 3) == 0) begin
        fmt.push_back(CH_PERCENT);
        fmt.push_back(CH_PERCENT);
      end
      fmt.push_back(CH_PERCENT);
      repeat ($urandom_range(0, 4)) fmt.push_back(rand_flag());
      brk = (pick < 32) ? $urandom_range(1, 4) : 0;
      case (brk)
        1: begin
          fmt.push_back(LEN_MODS[$urandom_range(0, 3)]);
          fmt.push_back(rand_spec());
        end
        2: fmt.push_back(CH_NUL);
        3: ;
        4: fmt.push_back(8'($urandom_range(0, 255)));
        default: fmt.push_back(rand_spec());
      endcase
      if (brk != 3) repeat ($urandom_range(0, 3)) fmt.push_back(rand_literal());
      if (brk == 0 && $urandom_range(0, 5) == 0) begin
        fmt.push_back(CH_PERCENT);
        fmt.push_back(rand_spec());
      end
    end
    foreach (fmt[k]) format_bytes.push_back('{ch: fmt[k], fin: k == fmt.size() - 1});
  endtask

  // driver: one transaction per accepted byte, payload held while stalled
  always @(posedge clk) begin
    logic       nxt_valid;
    fmt_byte_t  nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt = '{ch: in_format_char, fin: in_last_of_format};
      if (in_valid && !in_stall) begin
        predict_rebuilt(in_format_char, in_last_of_format);
        items_accepted <= items_accepted + 1;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && format_bytes.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
        nxt = format_bytes.pop_front();
        nxt_valid = 1'b1;
      end
      in_valid          <= nxt_valid;
      in_format_char    <= nxt.ch;
      in_last_of_format <= nxt.fin;
    end
  end

  // receiver stall, with one long hold-off to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_accepted >= total_items / 6) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    rebuilt_t got;
    rebuilt_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{ch: out_rebuilt_char, verdict: out_is_verdict, kind: out_format_kind,
              last: out_last_of_run};
      if (expected_rebuilt.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected transaction: char %h verdict %b kind %0d last %b",
                   got.ch, got.verdict, got.kind, got.last);
        mismatches++;
      end else begin
        want = expected_rebuilt.pop_front();
        if (got.ch !== want.ch || got.verdict !== want.verdict || got.kind !== want.kind ||
            got.last !== want.last) begin
          if (mismatches < 10)
            $display("mismatch: expected char %h verdict %b kind %0d last %b, got char %h verdict %b kind %0d last %b",
                     want.ch, want.verdict, want.kind, want.last,
                     got.ch, got.verdict, got.kind, got.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    clear_scan();
    add_text("%i", 1'b1);
    add_text("%#.3f", 1'b1);
    add_text("%%", 1'b0);
    format_bytes.push_back('{ch: 8'hFF, fin: 1'b0});
    add_text("%u", 1'b1);
    format_bytes.push_back('{ch: CH_NUL, fin: 1'b0});
    add_text("%d", 1'b1);
    add_text("%d%x", 1'b1);
    add_text("%lu", 1'b1);
    add_text("%", 1'b1);
    add_text("q", 1'b1);
    while (format_bytes.size() < 400) add_random_format();
    total_items = format_bytes.size();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (items_accepted < total_items) @(posedge clk);
    while (expected_rebuilt.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS print_format_checker");
    end else begin
      $display("FAIL print_format_checker");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL print_format_checker");
    $finish;
  end

endmodule
